/* rtl/core/grid_point_to_cell_index_unit_defines.svh */
// assertion macros for the grid point binning rtl
`ifndef GRID_POINT_TO_CELL_INDEX_UNIT_DEFINES_SVH
`define GRID_POINT_TO_CELL_INDEX_UNIT_DEFINES_SVH

// checked on every clock edge outside reset
`define GPCI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define GPCI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/gpci_pkg.sv */
// constants shared by the grid point binning rtl
`timescale 1ns / 1ps
`default_nettype none

package gpci_pkg;

  localparam int COORD_BITS         = 32;
  localparam int MAX_CELLS_PER_AXIS = 1024;
  localparam int STEP_BITS          = 31;
  localparam int COUNT_FIELD_BITS   = 11;
  localparam int COUNTS_BITS        = 3 * COUNT_FIELD_BITS;
  localparam int DIMS_BITS          = 2;
  localparam int INDEX_BITS         = 30;
  localparam int AXIS_BITS          = 10;

  localparam int QUOT_BITS   = $clog2(MAX_CELLS_PER_AXIS);
  localparam int CNT_BITS    = QUOT_BITS + 1;
  localparam int AXIS_STAGES = QUOT_BITS + 3;

  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = COUNTS_BITS;

  localparam logic [CFG_ADDR_BITS-1:0] REG_DIMS        = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LOW_X       = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LOW_Y       = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LOW_Z       = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_STEP_X      = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_STEP_Y      = 3'd5;
  localparam logic [CFG_ADDR_BITS-1:0] REG_STEP_Z      = 3'd6;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CELL_COUNTS = 3'd7;

  localparam logic [DIMS_BITS-1:0]   DIMS_RESET   = 2'd3;
  localparam logic [STEP_BITS-1:0]   STEP_RESET   = 31'd65536;
  localparam logic [COUNTS_BITS-1:0] COUNTS_RESET = 33'd4196353;

endpackage

`default_nettype wire

/* rtl/core/gpci_point_if.sv */
// point channel: valid, ready and the three coordinates
`timescale 1ns / 1ps
`default_nettype none

interface gpci_point_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [gpci_pkg::COORD_BITS-1:0]    point_x;
  logic signed [gpci_pkg::COORD_BITS-1:0]    point_y;
  logic signed [gpci_pkg::COORD_BITS-1:0]    point_z;

  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

`default_nettype wire

/* rtl/core/gpci_cell_if.sv */
// result channel: valid, ready, linear index, outside flag and per-axis cells
`timescale 1ns / 1ps
`default_nettype none

interface gpci_cell_if;
  logic                              valid;
  logic                              ready;
  logic [gpci_pkg::INDEX_BITS-1:0]   cell_index;
  logic                              outside;
  logic [gpci_pkg::AXIS_BITS-1:0]    column;
  logic [gpci_pkg::AXIS_BITS-1:0]    row;
  logic [gpci_pkg::AXIS_BITS-1:0]    layer;

  modport source (output valid, output cell_index, output outside, output column,
                  output row, output layer, input ready);
  modport sink   (input valid, input cell_index, input outside, input column,
                  input row, input layer, output ready);
endinterface

`default_nettype wire

/* rtl/core/gpci_axis.sv */
// one axis: range check and pipelined restoring division, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none

module gpci_axis (
  input  logic                                   clk,
  input  logic [gpci_pkg::AXIS_STAGES-1:0]       en,
  input  logic signed [gpci_pkg::COORD_BITS-1:0] point,
  input  logic signed [gpci_pkg::COORD_BITS-1:0] low,
  input  logic [gpci_pkg::STEP_BITS-1:0]         step,
  input  logic [gpci_pkg::CNT_BITS-1:0]          count,
  output logic [gpci_pkg::QUOT_BITS-1:0]         cell_num,
  output logic                                   outside
);

  localparam int CB   = gpci_pkg::COORD_BITS;
  localparam int QB   = gpci_pkg::QUOT_BITS;
  localparam int NB   = gpci_pkg::CNT_BITS;
  localparam int WIDE = gpci_pkg::STEP_BITS + gpci_pkg::CNT_BITS;

  logic signed [CB:0] diff;
  logic [WIDE-1:0]    prod;

  logic [CB-1:0] rem  [0:QB];
  logic [QB-1:0] quo  [0:QB];
  logic          neg  [0:QB];
  logic          sat  [0:QB];
  logic          miss [0:QB];

  // offset from the lower corner and the box width
  always_ff @(posedge clk) begin
    if (en[0]) begin
      diff <= {point[CB-1], point} - {low[CB-1], low};
      prod <= WIDE'(step) * WIDE'(count);
    end
  end

  // range check and quotient overflow, then msb first, one compare and subtract per stage
  always_ff @(posedge clk) begin
    if (en[1]) begin
      neg[0]  <= diff[CB];
      miss[0] <= diff[CB] || (WIDE'(diff[CB-1:0]) > prod);
      sat[0]  <= WIDE'(diff[CB-1:0]) >= (WIDE'(step) << QB);
      rem[0]  <= diff[CB-1:0];
      quo[0]  <= '0;
    end
    for (int j = 0; j < QB; j++) begin
      if (en[2 + j]) begin
        if (WIDE'(rem[j]) >= (WIDE'(step) << (QB - 1 - j))) begin
          rem[j + 1] <= CB'(WIDE'(rem[j]) - (WIDE'(step) << (QB - 1 - j)));
          quo[j + 1] <= quo[j] | (QB'(1) << (QB - 1 - j));
        end else begin
          rem[j + 1] <= rem[j];
          quo[j + 1] <= quo[j];
        end
        neg[j + 1]  <= neg[j];
        sat[j + 1]  <= sat[j];
        miss[j + 1] <= miss[j];
      end
    end
  end

  // below the box gives 0, at or past the count gives count - 1
  always_ff @(posedge clk) begin
    if (en[QB + 2]) begin
      if (neg[QB]) begin
        cell_num <= '0;
      end else if (sat[QB] || (NB'(quo[QB]) >= count)) begin
        cell_num <= QB'(count - NB'(1));
      end else begin
        cell_num <= quo[QB];
      end
      outside <= miss[QB];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/grid_point_to_cell_index_unit.sv */
// Uniform grid point binning, 1 to 3 axes, signed Q16.16 coordinates.
//
// Channels: points (sink) carries point_x/y/z; results (source) carries
// cell_index, outside, column, row and layer. An item moves on a clock edge
// with valid and ready both high. Grid set-up goes through the write port
// (cfg_we, cfg_addr, cfg_data), registers 0..7: dims, low_x/y/z,
// step_x/y/z, cell_counts. Write it only while no item is in flight.
//
// Pipeline: a result reaches results through 15 register stages: per axis
// one stage for the offset and box width, one for the range check, one per
// quotient bit of the restoring divider (10 stages), one for the clamp, then
// one for the row-major sum and one for the final multiply into the output
// register. Throughput is one item per cycle while results.ready stays high.
//
// Reset (synchronous, rst) empties the pipeline and loads the default grid:
// 3 axes, corner 0, step 1.0, one cell per axis. On a receiver stall, items
// hold unless a later stage is empty, and points.ready stays high while any stage is empty.
`timescale 1ns / 1ps
`default_nettype none

module grid_point_to_cell_index_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [gpci_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [gpci_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  gpci_point_if.sink                           points,
  gpci_cell_if.source                          results
);

`include "grid_point_to_cell_index_unit_defines.svh"

  localparam int CB     = gpci_pkg::COORD_BITS;
  localparam int SB     = gpci_pkg::STEP_BITS;
  localparam int FB     = gpci_pkg::COUNT_FIELD_BITS;
  localparam int QB     = gpci_pkg::QUOT_BITS;
  localparam int NB     = gpci_pkg::CNT_BITS;
  localparam int AS     = gpci_pkg::AXIS_STAGES;
  localparam int NSTAGE = AS + 2;
  localparam int TB     = QB + NB;
  localparam int XB     = TB + NB;

  logic [gpci_pkg::DIMS_BITS-1:0]   dims;
  logic signed [CB-1:0]             low_x;
  logic signed [CB-1:0]             low_y;
  logic signed [CB-1:0]             low_z;
  logic [SB-1:0]                    step_x;
  logic [SB-1:0]                    step_y;
  logic [SB-1:0]                    step_z;
  logic [gpci_pkg::COUNTS_BITS-1:0] cell_counts;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] rdy;

  logic [NB-1:0] nx, ny, nz;
  logic [QB-1:0] cell_x, cell_y, cell_z;
  logic          out_x, out_y, out_z;
  logic          act_x, act_y, act_z;

  logic [TB-1:0] tsum;
  logic [QB-1:0] col_r, row_r, lay_r;
  logic          miss_r;

  function automatic logic [NB-1:0] count_eff(input logic [FB-1:0] f);
    if (f == '0) begin
      return NB'(1);
    end
    if (int'(f) > gpci_pkg::MAX_CELLS_PER_AXIS) begin
      return NB'(gpci_pkg::MAX_CELLS_PER_AXIS);
    end
    return NB'(f);
  endfunction

  function automatic logic [SB-1:0] step_eff(input logic [SB-1:0] s);
    return (s == '0) ? SB'(1) : s;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      dims        <= gpci_pkg::DIMS_RESET;
      low_x       <= '0;
      low_y       <= '0;
      low_z       <= '0;
      step_x      <= gpci_pkg::STEP_RESET;
      step_y      <= gpci_pkg::STEP_RESET;
      step_z      <= gpci_pkg::STEP_RESET;
      cell_counts <= gpci_pkg::COUNTS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        gpci_pkg::REG_DIMS:        dims        <= cfg_data[gpci_pkg::DIMS_BITS-1:0];
        gpci_pkg::REG_LOW_X:       low_x       <= cfg_data[CB-1:0];
        gpci_pkg::REG_LOW_Y:       low_y       <= cfg_data[CB-1:0];
        gpci_pkg::REG_LOW_Z:       low_z       <= cfg_data[CB-1:0];
        gpci_pkg::REG_STEP_X:      step_x      <= cfg_data[SB-1:0];
        gpci_pkg::REG_STEP_Y:      step_y      <= cfg_data[SB-1:0];
        gpci_pkg::REG_STEP_Z:      step_z      <= cfg_data[SB-1:0];
        gpci_pkg::REG_CELL_COUNTS: cell_counts <= cfg_data[gpci_pkg::COUNTS_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign nx    = count_eff(cell_counts[FB-1:0]);
  assign ny    = count_eff(cell_counts[2*FB-1:FB]);
  assign nz    = count_eff(cell_counts[3*FB-1:2*FB]);
  assign act_x = (dims >= 2'd1);
  assign act_y = (dims >= 2'd2);
  assign act_z = (dims == 2'd3);

  // a stage takes a new item when results.ready is high or it or any stage after it is empty
  for (genvar i = 0; i < NSTAGE; i++) begin : g_rdy
    assign rdy[i] = results.ready || !(&vld[NSTAGE-1:i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= points.valid;
      end
      for (int i = 1; i < NSTAGE; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i - 1];
        end
      end
    end
  end

  assign points.ready  = rdy[0];
  assign results.valid = vld[NSTAGE-1];

  gpci_axis u_axis_x (
    .clk      (clk),
    .en       (rdy[AS-1:0]),
    .point    (points.point_x),
    .low      (low_x),
    .step     (step_eff(step_x)),
    .count    (nx),
    .cell_num (cell_x),
    .outside  (out_x)
  );

  gpci_axis u_axis_y (
    .clk      (clk),
    .en       (rdy[AS-1:0]),
    .point    (points.point_y),
    .low      (low_y),
    .step     (step_eff(step_y)),
    .count    (ny),
    .cell_num (cell_y),
    .outside  (out_y)
  );

  gpci_axis u_axis_z (
    .clk      (clk),
    .en       (rdy[AS-1:0]),
    .point    (points.point_z),
    .low      (low_z),
    .step     (step_eff(step_z)),
    .count    (nz),
    .cell_num (cell_z),
    .outside  (out_z)
  );

  // unused axes give 0 and never flag a miss
  always_ff @(posedge clk) begin
    if (rdy[AS]) begin
      col_r  <= act_x ? cell_x : '0;
      row_r  <= act_y ? cell_y : '0;
      lay_r  <= act_z ? cell_z : '0;
      tsum   <= TB'(act_z ? cell_z : '0) * TB'(ny) + TB'(act_y ? cell_y : '0);
      miss_r <= (act_x && out_x) || (act_y && out_y) || (act_z && out_z);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTAGE-1]) begin
      results.cell_index <= miss_r ? '0
                            : gpci_pkg::INDEX_BITS'(XB'(tsum) * XB'(nx) + XB'(col_r));
      results.outside    <= miss_r;
      results.column     <= gpci_pkg::AXIS_BITS'(col_r);
      results.row        <= gpci_pkg::AXIS_BITS'(row_r);
      results.layer      <= gpci_pkg::AXIS_BITS'(lay_r);
    end
  end

  `GPCI_ASSERT_ALWAYS(a_reset_empties, rst |=> (vld == '0), "pipeline not empty after reset")
  `GPCI_ASSERT(a_accept_fills, (points.valid && points.ready) |=> vld[0], "accepted item lost")
  `GPCI_ASSERT(a_stall_holds, (vld[NSTAGE-2] && !rdy[NSTAGE-1]) |=> vld[NSTAGE-2], "stall lost item")
  `GPCI_ASSERT(a_outside_zero, (results.valid && results.outside) |-> (results.cell_index == '0), "index not 0")

endmodule

`default_nettype wire

/* dv/gpci_bin_checker.sv */
// checker for the grid binning unit: predicts each cell result and compares them in order
`timescale 1ns / 1ps

module gpci_bin_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [gpci_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [gpci_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  gpci_point_if                               points,
  gpci_cell_if                                results,
  output int                                  fail_count,
  output int                                  pending
);
  import gpci_pkg::*;

  typedef struct packed {
    logic [INDEX_BITS-1:0] cell_index;
    logic                  outside;
    logic [AXIS_BITS-1:0]  column;
    logic [AXIS_BITS-1:0]  row;
    logic [AXIS_BITS-1:0]  layer;
  } bin_result_t;

  logic [DIMS_BITS-1:0]         grid_dims;
  logic signed [COORD_BITS-1:0] grid_low [3];
  logic [STEP_BITS-1:0]         grid_step [3];
  logic [COUNTS_BITS-1:0]       grid_counts;

  bin_result_t expected_bins [$];
  bin_result_t want;
  bin_result_t got;
  int          mismatches = 0;

  function automatic longint axis_cells(input int axis);
    logic [COUNT_FIELD_BITS-1:0] n;
    n = grid_counts[axis*COUNT_FIELD_BITS +: COUNT_FIELD_BITS];
    if (n == 0) return 1;
    if (n > MAX_CELLS_PER_AXIS) return MAX_CELLS_PER_AXIS;
    return longint'(n);
  endfunction

  function automatic logic [AXIS_BITS-1:0] bin_axis_cell(input int axis,
      input logic signed [COORD_BITS-1:0] coord, output logic miss);
    longint step_w, count, lo, hi, diff, slot;
    count  = axis_cells(axis);
    step_w = (grid_step[axis] == '0) ? 64'sd1 : longint'(grid_step[axis]);
    lo     = longint'(grid_low[axis]);
    hi     = lo + step_w * count;
    diff   = longint'(coord) - lo;
    miss   = (longint'(coord) > hi) || (longint'(coord) < lo);
    if (diff < 0) begin
      slot = 0;
    end else begin
      slot = diff / step_w;
    end
    // point on the upper face lands in the last cell
    if (slot >= count) slot = count - 1;
    return slot[AXIS_BITS-1:0];
  endfunction

  function automatic bin_result_t predict_bins(input logic signed [COORD_BITS-1:0] px,
      input logic signed [COORD_BITS-1:0] py, input logic signed [COORD_BITS-1:0] pz);
    bin_result_t r;
    logic        miss_x, miss_y, miss_z;
    longint      flat;
    r      = '0;
    miss_x = 1'b0;
    miss_y = 1'b0;
    miss_z = 1'b0;
    if (grid_dims >= 2'd3) r.layer  = bin_axis_cell(2, pz, miss_z);
    if (grid_dims >= 2'd2) r.row    = bin_axis_cell(1, py, miss_y);
    if (grid_dims >= 2'd1) r.column = bin_axis_cell(0, px, miss_x);
    r.outside = miss_x | miss_y | miss_z;
    flat = (longint'(r.layer) * axis_cells(1) + longint'(r.row)) * axis_cells(0)
           + longint'(r.column);
    if (!r.outside) r.cell_index = flat[INDEX_BITS-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      grid_dims   = DIMS_RESET;
      grid_counts = COUNTS_RESET;
      foreach (grid_low[a]) begin
        grid_low[a]  = '0;
        grid_step[a] = STEP_RESET;
      end
      expected_bins.delete();
    end else begin
      if (points.valid && points.ready) begin
        expected_bins.push_back(predict_bins(points.point_x, points.point_y, points.point_z));
      end
      if (results.valid && results.ready) begin
        got = {results.cell_index, results.outside, results.column, results.row,
               results.layer};
        if (expected_bins.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result item: index %0d outside %0b cell %0d/%0d/%0d",
                     $realtime, got.cell_index, got.outside, got.column, got.row, got.layer);
          end
        end else begin
          want = expected_bins.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch: exp index %0d outside %0b cell %0d/%0d/%0d",
                       $realtime, want.cell_index, want.outside, want.column, want.row,
                       want.layer);
              $display("%0t:                  got index %0d outside %0b cell %0d/%0d/%0d",
                       $realtime, got.cell_index, got.outside, got.column, got.row,
                       got.layer);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_DIMS: begin
            grid_dims = cfg_data[DIMS_BITS-1:0];
          end
          REG_LOW_X: begin
            grid_low[0] = cfg_data[COORD_BITS-1:0];
          end
          REG_LOW_Y: begin
            grid_low[1] = cfg_data[COORD_BITS-1:0];
          end
          REG_LOW_Z: begin
            grid_low[2] = cfg_data[COORD_BITS-1:0];
          end
          REG_STEP_X: begin
            grid_step[0] = cfg_data[STEP_BITS-1:0];
          end
          REG_STEP_Y: begin
            grid_step[1] = cfg_data[STEP_BITS-1:0];
          end
          REG_STEP_Z: begin
            grid_step[2] = cfg_data[STEP_BITS-1:0];
          end
          REG_CELL_COUNTS: begin
            grid_counts = cfg_data[COUNTS_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
    end
    fail_count <= mismatches;
    pending    <= expected_bins.size();
  end

endmodule

/* dv/tb_grid_point_to_cell_index_unit.sv */
// testbench top for the grid binning unit: grid set-ups, point stimulus and verdict
`timescale 1ns / 1ps

module tb_grid_point_to_cell_index_unit;
  import gpci_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int POINTS_PER_GRID = 134;

  localparam int GRID_RANDOM      = 0;
  localparam int GRID_LARGEST     = 1;
  localparam int GRID_SINGLE_CELL = 2;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  int                       fail_count;
  int                       pending;
  int                       send_idle_pct;
  int                       recv_idle_pct;
  bit                       hold_off_req;
  int                       cycle_count;

  logic signed [COORD_BITS-1:0] grid_low [3];
  logic [STEP_BITS-1:0]         grid_step [3];
  int                           grid_cells [3];

  gpci_point_if points_ch ();
  gpci_cell_if  bins_ch ();

  grid_point_to_cell_index_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .points   (points_ch),
    .results  (bins_ch)
  );

  gpci_bin_checker bin_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .points     (points_ch),
    .results    (bins_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : receiver
    bins_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        // long stall so the pipeline fills and points.ready drops
        hold_off_req = 1'b0;
        bins_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        bins_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_point(input logic signed [COORD_BITS-1:0] px,
      input logic signed [COORD_BITS-1:0] py, input logic signed [COORD_BITS-1:0] pz);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      points_ch.valid <= 1'b0;
      @(posedge clk);
    end
    points_ch.valid   <= 1'b1;
    points_ch.point_x <= px;
    points_ch.point_y <= py;
    points_ch.point_z <= pz;
    @(posedge clk);
    while (!points_ch.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    points_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
      input logic [CFG_DATA_BITS-1:0] data);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
  endtask

  // writes every register from grid_low/grid_step plus dims and counts,
  // at times with random junk above each register's width
  task automatic load_grid(input logic [DIMS_BITS-1:0] dims,
      input logic [COUNTS_BITS-1:0] counts);
    logic [CFG_DATA_BITS-1:0]    junk;
    logic [COUNT_FIELD_BITS-1:0] n;
    int                          a;
    junk = $urandom_range(0, 1) ? CFG_DATA_BITS'({$urandom, $urandom}) : '0;
    write_reg(REG_DIMS, {junk[CFG_DATA_BITS-1:DIMS_BITS], dims});
    write_reg(REG_LOW_X, {junk[CFG_DATA_BITS-1:COORD_BITS], grid_low[0]});
    write_reg(REG_LOW_Y, {junk[CFG_DATA_BITS-1:COORD_BITS], grid_low[1]});
    write_reg(REG_LOW_Z, {junk[CFG_DATA_BITS-1:COORD_BITS], grid_low[2]});
    write_reg(REG_STEP_X, {junk[CFG_DATA_BITS-1:STEP_BITS], grid_step[0]});
    write_reg(REG_STEP_Y, {junk[CFG_DATA_BITS-1:STEP_BITS], grid_step[1]});
    write_reg(REG_STEP_Z, {junk[CFG_DATA_BITS-1:STEP_BITS], grid_step[2]});
    write_reg(REG_CELL_COUNTS, counts);
    cfg_we <= 1'b0;
    for (a = 0; a < 3; a++) begin
      n = counts[a*COUNT_FIELD_BITS +: COUNT_FIELD_BITS];
      grid_cells[a] = (n == 0) ? 1 : (n > MAX_CELLS_PER_AXIS) ? MAX_CELLS_PER_AXIS : n;
    end
  endtask

  task automatic random_grid(input int shape);
    logic [DIMS_BITS-1:0]        dims;
    logic [COUNTS_BITS-1:0]      counts;
    logic [COUNT_FIELD_BITS-1:0] field;
    int                          a;
    int                          pick;
    dims = ($urandom_range(0, 19) == 0) ? 2'd0 : 2'($urandom_range(1, 3));
    for (a = 0; a < 3; a++) begin
      grid_low[a] = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1 << 30) - (1 << 29)
                                               : $urandom;
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        grid_step[a] = STEP_BITS'($urandom_range(1, 1 << 20));
      end else if (pick < 17) begin
        grid_step[a] = STEP_BITS'($urandom_range(1, 255));
      end else if (pick < 19) begin
        grid_step[a] = STEP_BITS'($urandom);
      end else begin
        grid_step[a] = '0;
      end
      pick = $urandom_range(0, 19);
      if (pick < 16) begin
        field = COUNT_FIELD_BITS'($urandom_range(1, MAX_CELLS_PER_AXIS));
      end else if (pick < 18) begin
        field = '0;
      end else begin
        field = COUNT_FIELD_BITS'($urandom_range(MAX_CELLS_PER_AXIS + 1, 2047));
      end
      if (shape == GRID_LARGEST) begin
        field        = COUNT_FIELD_BITS'(MAX_CELLS_PER_AXIS);
        grid_step[a] = STEP_BITS'($urandom_range(1, 1 << 16));
      end else if (shape == GRID_SINGLE_CELL) begin
        field = COUNT_FIELD_BITS'(1);
      end
      counts[a*COUNT_FIELD_BITS +: COUNT_FIELD_BITS] = field;
    end
    if (shape != GRID_RANDOM) dims = 2'd3;
    load_grid(dims, counts);
  endtask

  // mostly points inside the box, some on or next to its faces, the rest anywhere
  function automatic logic [COORD_BITS-1:0] pick_coord(input int axis);
    longint s, lo, hi, v;
    int     pick;
    s    = (grid_step[axis] == '0) ? 64'sd1 : longint'(grid_step[axis]);
    lo   = longint'(grid_low[axis]);
    hi   = lo + s * grid_cells[axis];
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      v = lo + s * longint'($urandom_range(0, grid_cells[axis] - 1)) + longint'($urandom) % s;
    end else if (pick < 85) begin
      case ($urandom_range(0, 5))
        0: begin
          v = lo;
        end
        1: begin
          v = lo - 1;
        end
        2: begin
          v = hi;
        end
        3: begin
          v = hi + 1;
        end
        4: begin
          v = hi - 1;
        end
        default: begin
          v = lo + s * longint'($urandom_range(0, grid_cells[axis]));
        end
      endcase
    end else begin
      v = longint'($urandom);
    end
    return v[COORD_BITS-1:0];
  endfunction

  initial begin : stimulus
    int phase;
    int k;
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_addr          <= '0;
    cfg_data          <= '0;
    points_ch.valid   <= 1'b0;
    points_ch.point_x <= '0;
    points_ch.point_y <= '0;
    points_ch.point_z <= '0;
    send_idle_pct = 8;
    recv_idle_pct = 78;
    hold_off_req  = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // default grid: one unit cell per axis
    send_point(32'sd0, 32'sd0, 32'sd0);
    send_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000);
    send_point(-32'sd1, 32'sd0, 32'sd0);
    wait_idle();

    // x -10..5 step 1.5, y 0..5 step 1, z 2.25..3.75 step 0.5
    grid_low[0]  = -32'sd655360;
    grid_low[1]  = 32'sd0;
    grid_low[2]  = 32'sd147456;
    grid_step[0] = 31'd98304;
    grid_step[1] = 31'd65536;
    grid_step[2] = 31'd32768;
    load_grid(2'd3, {11'd3, 11'd5, 11'd10});
    send_point(-32'sd655360, 32'sd0, 32'sd147456);
    send_point(32'sd327680, 32'sd327680, 32'sd245760);
    send_point(32'sd327681, 32'sd0, 32'sd147456);
    send_point(-32'sd655361, 32'sd0, 32'sd147456);
    send_point(32'sd0, -32'sd1, 32'sd200000);
    send_point(32'sd0, 32'sd327681, 32'sd200000);
    send_point(32'sd0, 32'sd100000, 32'sd245761);
    send_point(32'sd0, 32'sd100000, 32'sd147455);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_point(-32'sd1, 32'sd200000, 32'sd180000);
    wait_idle();

    // no active axis
    load_grid(2'd0, {11'd3, 11'd5, 11'd10});
    send_point(32'sd1, 32'sd2, 32'sd3);
    send_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    wait_idle();

    // x only, zero step and zero count at the top of the range
    grid_low[0]  = 32'sh7fff_fffe;
    grid_step[0] = '0;
    load_grid(2'd1, {11'd7, 11'd9, 11'd0});
    send_point(32'sh7fff_fffe, $urandom, $urandom);
    send_point(32'sh7fff_ffff, $urandom, $urandom);
    send_point(32'sh7fff_fffd, $urandom, $urandom);
    wait_idle();

    // widest steps from the bottom of the range, counts above the maximum
    grid_low[0]  = 32'sh8000_0000;
    grid_low[1]  = 32'sh8000_0000;
    grid_step[0] = 31'h7fff_ffff;
    grid_step[1] = 31'h7fff_ffff;
    load_grid(2'd2, 33'h1_ffff_ffff);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sd0);
    send_point(32'sh8000_0000, 32'sh8000_0000, 32'sd0);
    send_point(32'sd0, -32'sd1, 32'sd0);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 78;
        end
        1: begin
          send_idle_pct = 78;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (k = 0; k < 4; k++) begin
        wait_idle();
        if (k == 0 && phase == 0) begin
          random_grid(GRID_LARGEST);
        end else if (k == 0 && phase == 1) begin
          random_grid(GRID_SINGLE_CELL);
        end else begin
          random_grid(GRID_RANDOM);
        end
        if (phase == 2 && k == 0) hold_off_req = 1'b1;
        repeat (POINTS_PER_GRID) send_point(pick_coord(0), pick_coord(1), pick_coord(2));
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
